FILE: rtl/core/jegx_pkg.sv
// Shared types and constants for the JPEG Exif GPS extractor.
// Used by the top level and by the serial divider; depends on nothing.
`default_nettype none

package jegx_pkg;

    localparam int OFF_W      = 34;
    localparam int SEG_W      = 17;
    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = 44;
    localparam int SCALE_W    = 12;

    localparam logic [7:0] MARK_FF   = 8'hFF;
    localparam logic [7:0] MARK_SOI  = 8'hD8;
    localparam logic [7:0] MARK_APP1 = 8'hE1;
    localparam logic [7:0] MARK_SOS  = 8'hDA;

    localparam logic [15:0] TAG_MAKE     = 16'h010F;
    localparam logic [15:0] TAG_MODEL    = 16'h0110;
    localparam logic [15:0] TAG_DATETIME = 16'h0132;
    localparam logic [15:0] TAG_GPS_IFD  = 16'h8825;
    localparam logic [15:0] TAG_LAT_REF  = 16'h0001;
    localparam logic [15:0] TAG_LAT      = 16'h0002;
    localparam logic [15:0] TAG_LON_REF  = 16'h0003;
    localparam logic [15:0] TAG_LON      = 16'h0004;
    localparam logic [15:0] BOM_INTEL    = 16'h4949;

    localparam logic [7:0] ASCII_N = 8'h4E;
    localparam logic [7:0] ASCII_E = 8'h45;
    localparam logic [7:0] ASCII_S = 8'h53;
    localparam logic [7:0] ASCII_W = 8'h57;

    localparam logic [1:0] KIND_MAKE     = 2'd0;
    localparam logic [1:0] KIND_MODEL    = 2'd1;
    localparam logic [1:0] KIND_DATETIME = 2'd2;
    localparam logic [1:0] KIND_STATUS   = 2'd3;

    localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // Bytes of the "Exif\0\0" signature that opens the APP1 body.
    function automatic logic [7:0] exif_sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0: v = 8'h45;
            3'd1: v = 8'h78;
            3'd2: v = 8'h69;
            3'd3: v = 8'h66;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Divisor scale of each term: degrees, minutes, seconds.
    function automatic logic [SCALE_W-1:0] term_scale(input logic [1:0] term);
        logic [SCALE_W-1:0] v;
        case (term)
            2'd0: v = SCALE_W'(1);
            2'd1: v = SCALE_W'(60);
            2'd2: v = SCALE_W'(3600);
            default: v = SCALE_W'(1);
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/jegx_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on jegx_pkg for the operand widths.
`default_nettype none

module jegx_div import jegx_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [DIVIDEND_W-1:0]      o_quotient
);

    localparam int CW = $clog2(DIVIDEND_W);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIVIDEND_W - 1);
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

FILE: rtl/core/jpeg_exif_gps_extractor.sv
// Top level of the JPEG Exif GPS extractor: byte intake, TIFF store and directory walker.
// Depends on jegx_pkg and instantiates the serial divider jegx_div.
`default_nettype none

// The block takes a JPEG file one word (byte) per cycle while busy is low: a word is
// taken at each clock edge where start is high and busy is low. Intake walks the marker
// segments and copies the body of the first Exif APP1 segment into an internal store of
// TIFF_BYTES entries. When the word flagged end_of_file is taken, busy rises and the
// block walks IFD0 and the GPS directory from the store, reading one byte at a time
// through its single read port. It emits make, model and datetime in chunks of up to
// eight bytes and then one status record with last_of_run set, after which busy falls
// and the next file may start. Each result is shown for exactly one cycle with o_valid
// high; the receiver cannot hold results off, so it must take every word on the
// cycle it appears. The walk time depends on the directory sizes, the text lengths
// and, for each coordinate, up to three divisions in the shared divider.

module jpeg_exif_gps_extractor import jegx_pkg::*; #(
    parameter int TIFF_BYTES = 65536,
    parameter int TEXT_CAP   = 128,
    parameter int DATE_CAP   = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_file,
    output logic             busy,
    output logic             o_valid,
    output logic [1:0]       o_record_kind,
    output logic [63:0]      o_chunk_bytes,
    output logic [3:0]       o_chunk_count,
    output logic             o_parse_ok,
    output logic             o_has_geo,
    output logic signed [63:0] o_latitude,
    output logic signed [63:0] o_longitude,
    output logic             o_last_of_run
);

    localparam int AW     = $clog2(TIFF_BYTES);
    localparam int LW     = $clog2(TIFF_BYTES + 1);
    localparam int MAXCAP = (TEXT_CAP > DATE_CAP) ? TEXT_CAP : DATE_CAP;
    localparam int NW     = $clog2(MAXCAP);
    localparam logic [LW-1:0] TIFF_LIM = LW'(TIFF_BYTES);

    typedef enum logic [3:0] {
        P_SOI0, P_SOI1, P_MARK_FF, P_MARK_ID, P_LEN_HI, P_LEN_LO,
        P_SIG, P_SKIP, P_CAPTURE, P_DONE
    } t_phase;

    typedef enum logic [5:0] {
        S_IDLE, S_RD_ISSUE, S_RD_WAIT, S_INIT, S_CHK, S_BO, S_IFD0, S_N0,
        S_ENT0, S_TAG0, S_GPSOFF, S_CNT0, S_AOFF, S_ASC, S_ASC2, S_NEXT0,
        S_TSEL, S_TNEXT, S_TBYTE, S_TEND, S_GPS, S_GN, S_GENT, S_GTAG,
        S_GCNT, S_GIDX, S_GREF, S_GNEXT, S_COORD, S_CO, S_TNUM, S_TDEN,
        S_TMUL, S_TDIV, S_TWAIT, S_TADD, S_CFIN, S_GEO, S_STAT
    } t_seq;

    // The TIFF store: one write port for intake, one registered read port for the walker.
    logic [7:0] r_mem [TIFF_BYTES];
    logic [7:0] r_mem_q;
    logic       r_rd_ok;

    t_seq              r_state;
    t_seq              r_ret;
    t_phase            r_phase;
    logic [7:0]        r_marker;
    logic [15:0]       r_seg_len;
    logic [2:0]        r_sig_idx;
    logic [SEG_W-1:0]  r_seg_rem;
    logic [LW-1:0]     r_tiff_len;
    logic              r_exif;
    logic              r_le;
    logic [31:0]       r_gps;
    logic [7:0]        r_lat_ref;
    logic [7:0]        r_lon_ref;

    logic [OFF_W-1:0]  r_addr;
    logic [2:0]        r_rd_left;
    logic [1:0]        r_rd_k;
    logic [31:0]       r_acc;

    logic [15:0]       r_n;
    logic [15:0]       r_i;
    logic [OFF_W-1:0]  r_eoff;
    logic [15:0]       r_tag;
    logic [1:0]        r_tkind;
    logic [31:0]       r_cnt;
    logic [OFF_W-1:0]  r_aoff;
    logic [NW-1:0]     r_n1;
    logic [LW-1:0]     r_txt_off [3];
    logic [NW-1:0]     r_txt_n [3];
    logic [1:0]        r_kind;
    logic [NW-1:0]     r_pos;
    logic [3:0]        r_ccount;
    logic [63:0]       r_word;

    logic              r_ok;
    logic              r_geo;
    logic              r_has_la;
    logic              r_has_lo;
    logic [OFF_W-1:0]  r_la_e;
    logic [OFF_W-1:0]  r_lo_e;
    logic              r_sel;
    logic [OFF_W-1:0]  r_coff;
    logic [1:0]        r_term;
    logic [31:0]       r_num;
    logic [DIVISOR_W-1:0] r_divisor;
    logic              r_div_start;
    logic [63:0]       r_t;
    logic [63:0]       r_mag;
    logic [63:0]       r_la;
    logic [63:0]       r_lo;

    logic              r_o_valid;
    logic [1:0]        r_o_kind;
    logic [63:0]       r_o_bytes;
    logic [3:0]        r_o_count;
    logic              r_o_ok;
    logic              r_o_geo;
    logic [63:0]       r_o_lat;
    logic [63:0]       r_o_lon;
    logic              r_o_last;

    logic              take;
    logic              mem_we;
    logic [OFF_W-1:0]  tlen_x;
    logic [7:0]        rd_byte;
    logic [15:0]       seg_full;
    logic [31:0]       cap_lim;
    logic [SEG_W-1:0]  rem_dec;
    logic [LW-1:0]     len_inc;
    logic [31:0]       cap_m1;
    logic [31:0]       cnt_m1;
    logic [63:0]       word_ins;
    logic [7:0]        ref_byte;
    logic [63:0]       mag_room;
    logic              div_done;
    logic [DIVIDEND_W-1:0] div_quo;

    assign busy    = (r_state != S_IDLE);
    assign take    = start && !busy;
    assign mem_we  = take && (r_phase == P_CAPTURE) && (r_tiff_len < TIFF_LIM);
    assign tlen_x  = OFF_W'(r_tiff_len);
    assign rd_byte = r_rd_ok ? r_mem_q : 8'h00;

    // Capture length: body after the signature, or to end of file for a short length field.
    assign seg_full = {r_seg_len[15:8], i_data_byte};
    always_comb begin
        cap_lim = (r_seg_len >= 16'd8) ? (32'(r_seg_len) - 32'd8) : 32'(TIFF_BYTES);
        if (cap_lim > 32'(TIFF_BYTES)) begin
            cap_lim = 32'(TIFF_BYTES);
        end
    end
    assign rem_dec = (r_seg_rem != '0) ? (r_seg_rem - 1'b1) : '0;
    assign len_inc = (r_tiff_len < TIFF_LIM) ? (r_tiff_len + 1'b1) : r_tiff_len;

    assign cap_m1   = (r_tkind == KIND_DATETIME) ? 32'(DATE_CAP - 1) : 32'(TEXT_CAP - 1);
    assign cnt_m1   = r_cnt - 32'd1;
    assign word_ins = r_word | ({56'd0, r_acc[7:0]} << {r_ccount[2:0], 3'b000});
    assign ref_byte = r_sel ? r_lon_ref : r_lat_ref;
    assign mag_room = MAG_MAX - r_mag;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tiff_len[AW-1:0]] <= i_data_byte;
        end
        r_mem_q <= r_mem[r_addr[AW-1:0]];
        r_rd_ok <= (r_addr < tlen_x);
    end

    jegx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend ({r_num, 32'd0}),
        .i_divisor  (r_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= P_SOI0;
            r_tiff_len  <= '0;
            r_seg_rem   <= '0;
            r_sig_idx   <= '0;
            r_exif      <= 1'b0;
            r_le        <= 1'b0;
            r_gps       <= '0;
            r_lat_ref   <= ASCII_N;
            r_lon_ref   <= ASCII_E;
            r_div_start <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_o_valid   <= 1'b0;
            r_div_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        case (r_phase)
                            P_SOI0: r_phase <= (i_data_byte == MARK_FF) ? P_SOI1 : P_DONE;
                            P_SOI1: r_phase <= (i_data_byte == MARK_SOI) ? P_MARK_FF : P_DONE;
                            P_MARK_FF: r_phase <= (i_data_byte == MARK_FF) ? P_MARK_ID : P_DONE;
                            P_MARK_ID: begin
                                r_marker <= i_data_byte;
                                r_phase  <= P_LEN_HI;
                            end
                            P_LEN_HI: begin
                                r_seg_len <= {i_data_byte, 8'h00};
                                r_phase   <= P_LEN_LO;
                            end
                            P_LEN_LO: begin
                                r_seg_len <= seg_full;
                                if (r_marker == MARK_APP1) begin
                                    r_sig_idx <= '0;
                                    r_phase   <= P_SIG;
                                end else if (r_marker == MARK_SOS || seg_full < 16'd2) begin
                                    r_phase <= P_DONE;
                                end else begin
                                    r_seg_rem <= SEG_W'(seg_full - 16'd2);
                                    r_phase   <= (seg_full != 16'd2) ? P_SKIP : P_MARK_FF;
                                end
                            end
                            P_SIG: begin
                                if (r_sig_idx < 3'd6 && i_data_byte == exif_sig_byte(r_sig_idx)) begin
                                    r_sig_idx <= r_sig_idx + 1'b1;
                                    if (r_sig_idx == 3'd5) begin
                                        // Signature complete: capture the TIFF body.
                                        r_exif     <= 1'b1;
                                        r_tiff_len <= '0;
                                        r_seg_rem  <= SEG_W'(cap_lim);
                                        r_phase    <= (cap_lim != 32'd0) ? P_CAPTURE : P_DONE;
                                    end
                                end else if (r_seg_len < 16'd2 ||
                                             (r_seg_len - 16'd2) < 16'(r_sig_idx)) begin
                                    r_phase <= P_DONE;
                                end else if ((r_seg_len - 16'd2) == 16'(r_sig_idx)) begin
                                    // The segment ended inside the signature.
                                    r_phase <= (i_data_byte == MARK_FF) ? P_MARK_ID : P_DONE;
                                end else begin
                                    r_seg_rem <= SEG_W'(r_seg_len - 16'd3 - 16'(r_sig_idx));
                                    r_phase   <= ((r_seg_len - 16'd3 - 16'(r_sig_idx)) != 16'd0)
                                                 ? P_SKIP : P_MARK_FF;
                                end
                            end
                            P_SKIP: begin
                                r_seg_rem <= rem_dec;
                                if (rem_dec == '0) begin
                                    r_phase <= P_MARK_FF;
                                end
                            end
                            P_CAPTURE: begin
                                r_tiff_len <= len_inc;
                                r_seg_rem  <= rem_dec;
                                if (rem_dec == '0 || len_inc >= TIFF_LIM) begin
                                    r_phase <= P_DONE;
                                end
                            end
                            default: r_phase <= P_DONE;
                        endcase
                        if (i_end_of_file) begin
                            r_state <= S_INIT;
                        end
                    end
                end

                // Shared byte reader: assembles one to four bytes in the current byte order.
                S_RD_ISSUE: r_state <= S_RD_WAIT;
                S_RD_WAIT: begin
                    if (r_le) begin
                        r_acc[{r_rd_k, 3'b000} +: 8] <= rd_byte;
                    end else begin
                        r_acc <= {r_acc[23:0], rd_byte};
                    end
                    r_addr    <= r_addr + 1'b1;
                    r_rd_k    <= r_rd_k + 1'b1;
                    r_rd_left <= r_rd_left - 1'b1;
                    r_state   <= (r_rd_left == 3'd1) ? r_ret : S_RD_ISSUE;
                end

                S_INIT: begin
                    if (!r_exif) begin
                        r_tiff_len <= '0;
                    end
                    for (int k = 0; k < 3; k++) begin
                        r_txt_off[k] <= '0;
                        r_txt_n[k]   <= '0;
                    end
                    r_ok    <= 1'b0;
                    r_geo   <= 1'b0;
                    r_la    <= '0;
                    r_lo    <= '0;
                    r_kind  <= KIND_MAKE;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (tlen_x >= OFF_W'(8)) begin
                        r_addr <= '0; r_rd_left <= 3'd2; r_rd_k <= '0; r_acc <= '0;
                        r_ret <= S_BO; r_state <= S_RD_ISSUE;
                    end else begin
                        r_state <= S_STAT;
                    end
                end
                S_BO: begin
                    r_le <= (r_acc[15:0] == BOM_INTEL);
                    r_addr <= OFF_W'(4); r_rd_left <= 3'd4; r_rd_k <= '0; r_acc <= '0;
                    r_ret <= S_IFD0; r_state <= S_RD_ISSUE;
                end
                S_IFD0: begin
                    if (OFF_W'(r_acc) + OFF_W'(2) <= tlen_x) begin
                        r_ok   <= 1'b1;
                        r_eoff <= OFF_W'(r_acc) + OFF_W'(2);
                        r_addr <= OFF_W'(r_acc); r_rd_left <= 3'd2; r_rd_k <= '0;
                        r_acc <= '0; r_ret <= S_N0; r_state <= S_RD_ISSUE;
                    end else begin
                        r_state <= S_STAT;
                    end
                end
                S_N0: begin
                    r_n     <= r_acc[15:0];
                    r_i     <= '0;
                    r_state <= S_ENT0;
                end
                S_ENT0: begin
                    if (r_i < r_n && r_eoff + OFF_W'(12) <= tlen_x) begin
                        r_addr <= r_eoff; r_rd_left <= 3'd2; r_rd_k <= '0; r_acc <= '0;
                        r_ret <= S_TAG0; r_state <= S_RD_ISSUE;
                    end else begin
                        r_state <= S_TSEL;
                    end
                end
                S_TAG0: begin
                    r_rd_k <= '0;
                    r_acc  <= '0;
                    if (r_acc[15:0] == TAG_MAKE || r_acc[15:0] == TAG_MODEL ||
                        r_acc[15:0] == TAG_DATETIME) begin
                        r_tkind <= (r_acc[15:0] == TAG_MAKE)  ? KIND_MAKE :
                                   (r_acc[15:0] == TAG_MODEL) ? KIND_MODEL : KIND_DATETIME;
                        r_addr <= r_eoff + OFF_W'(4); r_rd_left <= 3'd4;
                        r_ret <= S_CNT0; r_state <= S_RD_ISSUE;
                    end else if (r_acc[15:0] == TAG_GPS_IFD) begin
                        r_addr <= r_eoff + OFF_W'(8); r_rd_left <= 3'd4;
                        r_ret <= S_GPSOFF; r_state <= S_RD_ISSUE;
                    end else begin
                        r_state <= S_NEXT0;
                    end
                end
                S_GPSOFF: begin
                    r_gps   <= r_acc;
                    r_state <= S_NEXT0;
                end
                S_CNT0: begin
                    r_cnt <= r_acc;
                    if (r_acc <= 32'd4) begin
                        // Short strings sit inside the entry itself.
                        r_aoff  <= r_eoff + OFF_W'(8);
                        r_state <= S_ASC;
                    end else begin
                        r_addr <= r_eoff + OFF_W'(8); r_rd_left <= 3'd4; r_rd_k <= '0;
                        r_acc <= '0; r_ret <= S_AOFF; r_state <= S_RD_ISSUE;
                    end
                end
                S_AOFF: begin
                    r_aoff  <= OFF_W'(r_acc);
                    r_state <= S_ASC;
                end
                S_ASC: begin
                    if (r_aoff >= tlen_x || r_cnt == 32'd0) begin
                        r_txt_off[r_tkind] <= '0;
                        r_txt_n[r_tkind]   <= '0;
                        r_state            <= S_NEXT0;
                    end else begin
                        r_n1    <= (cnt_m1 >= cap_m1) ? NW'(cap_m1) : NW'(cnt_m1);
                        r_state <= S_ASC2;
                    end
                end
                S_ASC2: begin
                    r_txt_off[r_tkind] <= r_aoff[LW-1:0];
                    if (r_aoff + OFF_W'(r_n1) > tlen_x) begin
                        r_txt_n[r_tkind] <= NW'(tlen_x - r_aoff);
                    end else begin
                        r_txt_n[r_tkind] <= r_n1;
                    end
                    r_state <= S_NEXT0;
                end
                S_NEXT0: begin
                    r_i     <= r_i + 1'b1;
                    r_eoff  <= r_eoff + OFF_W'(12);
                    r_state <= S_ENT0;
                end

                // Text emission, one byte per read, in chunks of up to eight bytes.
                S_TSEL: begin
                    if (r_kind == KIND_STATUS) begin
                        r_state <= S_GPS;
                    end else begin
                        r_pos    <= '0;
                        r_ccount <= '0;
                        r_word   <= '0;
                        r_state  <= S_TNEXT;
                    end
                end
                S_TNEXT: begin
                    if (r_pos < r_txt_n[r_kind]) begin
                        r_addr <= OFF_W'(r_txt_off[r_kind]) + OFF_W'(r_pos);
                        r_rd_left <= 3'd1; r_rd_k <= '0; r_acc <= '0;
                        r_ret <= S_TBYTE; r_state <= S_RD_ISSUE;
                    end else begin
                        r_state <= S_TEND;
                    end
                end
                S_TBYTE: begin
                    if (r_acc[7:0] == 8'h00) begin
                        r_state <= S_TEND;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                        if (r_ccount == 4'd7) begin
                            r_o_valid <= 1'b1;
                            r_o_kind  <= r_kind;
                            r_o_bytes <= word_ins;
                            r_o_count <= 4'd8;
                            r_o_ok    <= 1'b1;
                            r_o_geo   <= 1'b0;
                            r_o_lat   <= '0;
                            r_o_lon   <= '0;
                            r_o_last  <= 1'b0;
                            r_word    <= '0;
                            r_ccount  <= '0;
                        end else begin
                            r_word   <= word_ins;
                            r_ccount <= r_ccount + 1'b1;
                        end
                        r_state <= S_TNEXT;
                    end
                end
                S_TEND: begin
                    if (r_ccount != 4'd0) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= r_kind;
                        r_o_bytes <= r_word;
                        r_o_count <= r_ccount;
                        r_o_ok    <= 1'b1;
                        r_o_geo   <= 1'b0;
                        r_o_lat   <= '0;
                        r_o_lon   <= '0;
                        r_o_last  <= 1'b0;
                    end
                    r_kind  <= r_kind + 1'b1;
                    r_state <= S_TSEL;
                end

                // GPS directory walk.
                S_GPS: begin
                    if (r_gps != 32'd0 && OFF_W'(r_gps) + OFF_W'(2) <= tlen_x) begin
                        r_eoff <= OFF_W'(r_gps) + OFF_W'(2);
                        r_addr <= OFF_W'(r_gps); r_rd_left <= 3'd2; r_rd_k <= '0;
                        r_acc <= '0; r_ret <= S_GN; r_state <= S_RD_ISSUE;
                    end else begin
                        r_state <= S_STAT;
                    end
                end
                S_GN: begin
                    r_n      <= r_acc[15:0];
                    r_i      <= '0;
                    r_has_la <= 1'b0;
                    r_has_lo <= 1'b0;
                    r_state  <= S_GENT;
                end
                S_GENT: begin
                    if (r_i < r_n && r_eoff + OFF_W'(12) <= tlen_x) begin
                        r_addr <= r_eoff; r_rd_left <= 3'd2; r_rd_k <= '0; r_acc <= '0;
                        r_ret <= S_GTAG; r_state <= S_RD_ISSUE;
                    end else begin
                        r_state <= S_COORD;
                    end
                end
                S_GTAG: begin
                    r_tag  <= r_acc[15:0];
                    r_rd_k <= '0;
                    r_acc  <= '0;
                    if (r_acc[15:0] == TAG_LAT_REF || r_acc[15:0] == TAG_LON_REF) begin
                        r_addr <= r_eoff + OFF_W'(4); r_rd_left <= 3'd4;
                        r_ret <= S_GCNT; r_state <= S_RD_ISSUE;
                    end else if (r_acc[15:0] == TAG_LAT) begin
                        r_has_la <= 1'b1;
                        r_la_e   <= r_eoff;
                        r_state  <= S_GNEXT;
                    end else if (r_acc[15:0] == TAG_LON) begin
                        r_has_lo <= 1'b1;
                        r_lo_e   <= r_eoff;
                        r_state  <= S_GNEXT;
                    end else begin
                        r_state <= S_GNEXT;
                    end
                end
                S_GCNT: begin
                    r_addr <= r_eoff + OFF_W'(8); r_rd_k <= '0; r_acc <= '0;
                    r_state <= S_RD_ISSUE;
                    if (r_acc <= 32'd4) begin
                        r_rd_left <= 3'd1; r_ret <= S_GREF;
                    end else begin
                        r_rd_left <= 3'd4; r_ret <= S_GIDX;
                    end
                end
                S_GIDX: begin
                    r_addr <= OFF_W'(r_acc); r_rd_left <= 3'd1; r_rd_k <= '0; r_acc <= '0;
                    r_ret <= S_GREF; r_state <= S_RD_ISSUE;
                end
                S_GREF: begin
                    if (r_tag == TAG_LAT_REF) begin
                        r_lat_ref <= r_acc[7:0];
                    end else begin
                        r_lon_ref <= r_acc[7:0];
                    end
                    r_state <= S_GNEXT;
                end
                S_GNEXT: begin
                    r_i     <= r_i + 1'b1;
                    r_eoff  <= r_eoff + OFF_W'(12);
                    r_state <= S_GENT;
                end

                // Coordinates: three rational terms through the shared divider.
                S_COORD: begin
                    if (r_has_la && r_has_lo) begin
                        r_sel <= 1'b0;
                        r_addr <= r_la_e + OFF_W'(8); r_rd_left <= 3'd4; r_rd_k <= '0;
                        r_acc <= '0; r_ret <= S_CO; r_state <= S_RD_ISSUE;
                    end else begin
                        r_state <= S_STAT;
                    end
                end
                S_CO: begin
                    r_coff <= OFF_W'(r_acc);
                    r_mag  <= '0;
                    r_term <= '0;
                    r_state <= (OFF_W'(r_acc) + OFF_W'(24) > tlen_x) ? S_CFIN : S_TNUM;
                end
                S_TNUM: begin
                    r_addr <= r_coff + OFF_W'({r_term, 3'b000}); r_rd_left <= 3'd4;
                    r_rd_k <= '0; r_acc <= '0; r_ret <= S_TDEN; r_state <= S_RD_ISSUE;
                end
                S_TDEN: begin
                    r_num <= r_acc;
                    r_rd_left <= 3'd4; r_rd_k <= '0; r_acc <= '0;
                    r_ret <= S_TMUL; r_state <= S_RD_ISSUE;
                end
                S_TMUL: begin
                    if (r_acc == 32'd0) begin
                        r_t     <= '0;
                        r_state <= S_TADD;
                    end else begin
                        r_divisor <= DIVISOR_W'(r_acc) * DIVISOR_W'(term_scale(r_term));
                        r_state   <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    r_div_start <= 1'b1;
                    r_state     <= S_TWAIT;
                end
                S_TWAIT: begin
                    if (div_done) begin
                        r_t     <= div_quo;
                        r_state <= S_TADD;
                    end
                end
                S_TADD: begin
                    if (r_term == 2'd0) begin
                        r_mag <= (r_t > MAG_MAX) ? MAG_MAX : r_t;
                    end else begin
                        r_mag <= (r_t > mag_room) ? MAG_MAX : (r_mag + r_t);
                    end
                    r_term  <= r_term + 1'b1;
                    r_state <= (r_term == 2'd2) ? S_CFIN : S_TNUM;
                end
                S_CFIN: begin
                    if (!r_sel) begin
                        r_la <= (ref_byte == ASCII_S || ref_byte == ASCII_W) ? (64'd0 - r_mag)
                                                                             : r_mag;
                        r_sel <= 1'b1;
                        r_addr <= r_lo_e + OFF_W'(8); r_rd_left <= 3'd4; r_rd_k <= '0;
                        r_acc <= '0; r_ret <= S_CO; r_state <= S_RD_ISSUE;
                    end else begin
                        r_lo <= (ref_byte == ASCII_S || ref_byte == ASCII_W) ? (64'd0 - r_mag)
                                                                             : r_mag;
                        r_state <= S_GEO;
                    end
                end
                S_GEO: begin
                    r_geo   <= (r_la != 64'd0) || (r_lo != 64'd0);
                    r_state <= S_STAT;
                end
                S_STAT: begin
                    r_o_valid  <= 1'b1;
                    r_o_kind   <= KIND_STATUS;
                    r_o_bytes  <= '0;
                    r_o_count  <= '0;
                    r_o_ok     <= r_ok;
                    r_o_geo    <= r_geo;
                    r_o_lat    <= r_geo ? r_la : 64'd0;
                    r_o_lon    <= r_geo ? r_lo : 64'd0;
                    r_o_last   <= 1'b1;
                    // Back to the state after reset for the next file.
                    r_phase    <= P_SOI0;
                    r_tiff_len <= '0;
                    r_seg_rem  <= '0;
                    r_sig_idx  <= '0;
                    r_exif     <= 1'b0;
                    r_le       <= 1'b0;
                    r_gps      <= '0;
                    r_lat_ref  <= ASCII_N;
                    r_lon_ref  <= ASCII_E;
                    r_state    <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_record_kind = r_o_kind;
    assign o_chunk_bytes = r_o_bytes;
    assign o_chunk_count = r_o_count;
    assign o_parse_ok    = r_o_ok;
    assign o_has_geo     = r_o_geo;
    assign o_latitude    = r_o_lat;
    assign o_longitude   = r_o_lon;
    assign o_last_of_run = r_o_last;

    // The status word is the last one of a run and ends the busy period.
    a_status_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_run) |-> !busy)
        else $error("status word while the walker is still busy");

    // Text chunks only appear during the walk and are never empty.
    a_chunk_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_run) |-> (busy && o_chunk_count != 4'd0 &&
                                         o_chunk_count <= 4'd8))
        else $error("malformed text chunk");

    // The kind field and the last-of-run flag agree.
    a_kind_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_record_kind == KIND_STATUS) == o_last_of_run))
        else $error("record kind and last-of-run disagree");

endmodule

`default_nettype wire

FILE: test/tb_jpeg_exif_gps_extractor.sv
// Self-checking testbench for the JPEG Exif GPS extractor: builds JPEG files byte by byte,
// predicts every record and compares them field by field. Depends on jegx_pkg and the RTL.
`default_nettype none

module tb_jpeg_exif_gps_extractor;
    import jegx_pkg::*;

    localparam int STORE_BYTES = 65536;
    localparam int TEXT_LIMIT  = 128;
    localparam int DATE_LIMIT  = 64;
    localparam int IDLE_LIMIT  = 200000;

    // Intake phases of the marker walk.
    typedef enum int {
        PH_SOI0, PH_SOI1, PH_MARK_FF, PH_MARK_ID, PH_LEN_HI, PH_LEN_LO,
        PH_SIG, PH_SKIP, PH_CAPTURE, PH_DONE
    } intake_phase_t;

    typedef struct {
        logic [1:0]  kind;
        logic [63:0] text;
        logic [3:0]  count;
        logic        ok;
        logic        geo;
        logic [63:0] lat;
        logic [63:0] lon;
        logic        last;
    } exif_record_t;

    localparam logic [7:0] SIG_BYTES [0:5] = '{8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_end_of_file = 1'b0;
    logic        busy;
    logic        o_valid;
    logic [1:0]  o_record_kind;
    logic [63:0] o_chunk_bytes;
    logic [3:0]  o_chunk_count;
    logic        o_parse_ok;
    logic        o_has_geo;
    logic signed [63:0] o_latitude;
    logic signed [63:0] o_longitude;
    logic        o_last_of_run;

    jpeg_exif_gps_extractor dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_data_byte(i_data_byte),
        .i_end_of_file(i_end_of_file), .busy(busy), .o_valid(o_valid),
        .o_record_kind(o_record_kind), .o_chunk_bytes(o_chunk_bytes),
        .o_chunk_count(o_chunk_count), .o_parse_ok(o_parse_ok), .o_has_geo(o_has_geo),
        .o_latitude(o_latitude), .o_longitude(o_longitude), .o_last_of_run(o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of everything the block remembers.
    // ------------------------------------------------------------------
    logic [7:0]    tiff_copy [0:STORE_BYTES-1];
    logic [63:0]   tiff_len;
    intake_phase_t phase;
    logic [63:0]   seg_remaining;
    logic [63:0]   seg_length;
    int            sig_pos;
    logic [7:0]    marker;
    bit            exif_seen;
    bit            intel_order;
    logic [63:0]   gps_dir;
    logic [7:0]    lat_ref;
    logic [7:0]    lon_ref;

    exif_record_t  pending_records [$];
    exif_record_t  got_rec;
    int            error_count = 0;
    int            records_seen = 0;
    int            words_sent = 0;
    int            idle_cycles = 0;
    bit            gaps_on = 1'b1;

    // File under construction: the TIFF block and the whole JPEG stream.
    logic [7:0]    tiff_img [$];
    logic [7:0]    jpeg_img [$];
    bit            img_intel;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h (record %0d)", what, got, want,
                 records_seen);
        error_count++;
    endtask

    // Every state bit except the store returns to its reset value between files.
    function automatic void clear_parser();
        tiff_len = 0;
        phase = PH_SOI0;
        seg_remaining = 0;
        seg_length = 0;
        sig_pos = 0;
        marker = 8'h00;
        exif_seen = 1'b0;
        intel_order = 1'b0;
        gps_dir = 0;
        lat_ref = ASCII_N;
        lon_ref = ASCII_E;
    endfunction

    // Reads past the captured block, or past the store, give zero.
    function automatic logic [7:0] store_byte(input logic [63:0] off);
        if (off >= tiff_len || off >= STORE_BYTES) return 8'h00;
        return tiff_copy[off[15:0]];
    endfunction

    function automatic logic [15:0] store_half(input logic [63:0] off);
        logic [7:0] a, b;
        a = store_byte(off);
        b = store_byte(off + 1);
        return intel_order ? {b, a} : {a, b};
    endfunction

    function automatic logic [31:0] store_word(input logic [63:0] off);
        logic [7:0] a, b, c, d;
        a = store_byte(off);
        b = store_byte(off + 1);
        c = store_byte(off + 2);
        d = store_byte(off + 3);
        return intel_order ? {d, c, b, a} : {a, b, c, d};
    endfunction

    function automatic void begin_capture();
        logic [63:0] limit;
        limit = (seg_length >= 8) ? seg_length - 8 : STORE_BYTES;
        if (limit > STORE_BYTES) limit = STORE_BYTES;
        exif_seen = 1'b1;
        tiff_len = 0;
        seg_remaining = limit;
        phase = (limit != 0) ? PH_CAPTURE : PH_DONE;
    endfunction

    function automatic void skip_segment(input logic [63:0] rem);
        seg_remaining = rem;
        phase = (rem != 0) ? PH_SKIP : PH_MARK_FF;
    endfunction

    // Marker walk for one byte of the file.
    function automatic void walk_byte(input logic [7:0] b);
        case (phase)
            PH_SOI0: phase = (b == MARK_FF) ? PH_SOI1 : PH_DONE;
            PH_SOI1: phase = (b == MARK_SOI) ? PH_MARK_FF : PH_DONE;
            PH_MARK_FF: phase = (b == MARK_FF) ? PH_MARK_ID : PH_DONE;
            PH_MARK_ID: begin
                marker = b;
                phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                seg_length = {48'd0, b, 8'd0};
                phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                seg_length = seg_length | b;
                if (marker == MARK_APP1) begin
                    sig_pos = 0;
                    phase = PH_SIG;
                end else if (marker == MARK_SOS || seg_length < 2) begin
                    phase = PH_DONE;
                end else begin
                    skip_segment(seg_length - 2);
                end
            end
            PH_SIG: begin
                if (sig_pos < 6 && b == SIG_BYTES[sig_pos]) begin
                    sig_pos++;
                    if (sig_pos == 6) begin_capture();
                end else if (seg_length < 2 || seg_length - 2 < sig_pos) begin
                    phase = PH_DONE;
                end else if (seg_length - 2 == sig_pos) begin
                    // The segment ended inside the signature: this byte is the next marker.
                    phase = (b == MARK_FF) ? PH_MARK_ID : PH_DONE;
                end else begin
                    skip_segment(seg_length - 2 - sig_pos - 1);
                end
            end
            PH_SKIP: begin
                if (seg_remaining != 0) seg_remaining--;
                if (seg_remaining == 0) phase = PH_MARK_FF;
            end
            PH_CAPTURE: begin
                if (tiff_len < STORE_BYTES) begin
                    tiff_copy[tiff_len[15:0]] = b;
                    tiff_len++;
                end
                if (seg_remaining != 0) seg_remaining--;
                if (seg_remaining == 0 || tiff_len >= STORE_BYTES) phase = PH_DONE;
            end
            default: phase = PH_DONE;
        endcase
    endfunction

    // Where an ASCII tag's text lives and how many bytes of it may be used.
    function automatic void locate_text(input logic [63:0] eoff, input int cap,
                                        output logic [63:0] toff, output logic [63:0] tn);
        logic [31:0] cnt;
        logic [63:0] off;
        cnt = store_word(eoff + 4);
        off = (cnt <= 4) ? eoff + 8 : {32'd0, store_word(eoff + 8)};
        toff = 0;
        tn = 0;
        if (off >= tiff_len || cnt == 0) return;
        tn = cnt - 1;
        if (tn >= cap) tn = cap - 1;
        if (off + tn > tiff_len) tn = tiff_len - off;
        toff = off;
    endfunction

    function automatic void expect_text(input logic [1:0] kind, input logic [63:0] toff,
                                        input logic [63:0] tn);
        logic [63:0] len;
        exif_record_t r;
        len = 0;
        while (len < tn && store_byte(toff + len) != 8'h00) len++;
        for (logic [63:0] i = 0; i < len; i += 8) begin
            r = '{kind: kind, text: 64'd0, count: 4'd0, ok: 1'b1, geo: 1'b0,
                  lat: 64'd0, lon: 64'd0, last: 1'b0};
            for (int j = 0; j < 8 && i + j < len; j++) begin
                r.text[8*j +: 8] = store_byte(toff + i + j);
                r.count++;
            end
            pending_records.push_back(r);
        end
    endfunction

    // One rational term as Q.32, truncated, scaled down by k.
    function automatic logic [63:0] q32_term(input logic [63:0] off, input logic [63:0] k);
        logic [31:0] num, den;
        num = store_word(off);
        den = store_word(off + 4);
        if (den == 0) return 64'd0;
        return {num, 32'd0} / ({32'd0, den} * k);
    endfunction

    function automatic logic [63:0] degrees_q32(input logic [63:0] eoff, input logic [7:0] ref_ch);
        logic [63:0] off, mag, t;
        off = {32'd0, store_word(eoff + 8)};
        if (off + 24 > tiff_len) return 64'd0;
        mag = q32_term(off, 1);
        if (mag > MAG_MAX) mag = MAG_MAX;
        t = q32_term(off + 8, 60);
        mag = (t > MAG_MAX - mag) ? MAG_MAX : mag + t;
        t = q32_term(off + 16, 3600);
        mag = (t > MAG_MAX - mag) ? MAG_MAX : mag + t;
        if (ref_ch == ASCII_S || ref_ch == ASCII_W) return 64'd0 - mag;
        return mag;
    endfunction

    // Directory walk at end of file: queues text chunks and the status record.
    function automatic void walk_directories();
        logic [63:0] tl, ifd0, n, eoff, gps, la_e, lo_e, la, lo, idx;
        logic [63:0] toff [0:2];
        logic [63:0] tn [0:2];
        logic [15:0] tag;
        logic [31:0] cnt;
        bit ok, geo, has_la, has_lo;
        exif_record_t r;
        ok = 1'b0;
        geo = 1'b0;
        la = 0;
        lo = 0;
        for (int t = 0; t < 3; t++) begin
            toff[t] = 0;
            tn[t] = 0;
        end
        if (!exif_seen) tiff_len = 0;
        tl = tiff_len;
        if (tl >= 8) begin
            intel_order = (store_byte(0) == 8'h49 && store_byte(1) == 8'h49);
            ifd0 = {32'd0, store_word(4)};
            if (ifd0 + 2 <= tl) begin
                ok = 1'b1;
                n = store_half(ifd0);
                for (logic [63:0] i = 0; i < n; i++) begin
                    eoff = ifd0 + 2 + i * 12;
                    if (eoff + 12 > tl) break;
                    tag = store_half(eoff);
                    if (tag == TAG_MAKE) locate_text(eoff, TEXT_LIMIT, toff[0], tn[0]);
                    else if (tag == TAG_MODEL) locate_text(eoff, TEXT_LIMIT, toff[1], tn[1]);
                    else if (tag == TAG_DATETIME) locate_text(eoff, DATE_LIMIT, toff[2], tn[2]);
                    else if (tag == TAG_GPS_IFD) gps_dir = {32'd0, store_word(eoff + 8)};
                end
                expect_text(KIND_MAKE, toff[0], tn[0]);
                expect_text(KIND_MODEL, toff[1], tn[1]);
                expect_text(KIND_DATETIME, toff[2], tn[2]);
                gps = gps_dir;
                if (gps != 0 && gps + 2 <= tl) begin
                    has_la = 1'b0;
                    has_lo = 1'b0;
                    la_e = 0;
                    lo_e = 0;
                    n = store_half(gps);
                    for (logic [63:0] i = 0; i < n; i++) begin
                        eoff = gps + 2 + i * 12;
                        if (eoff + 12 > tl) break;
                        tag = store_half(eoff);
                        cnt = store_word(eoff + 4);
                        idx = (cnt <= 4) ? eoff + 8 : {32'd0, store_word(eoff + 8)};
                        if (tag == TAG_LAT_REF) lat_ref = store_byte(idx);
                        else if (tag == TAG_LAT) begin
                            has_la = 1'b1;
                            la_e = eoff;
                        end else if (tag == TAG_LON_REF) lon_ref = store_byte(idx);
                        else if (tag == TAG_LON) begin
                            has_lo = 1'b1;
                            lo_e = eoff;
                        end
                    end
                    if (has_la && has_lo) begin
                        la = degrees_q32(la_e, lat_ref);
                        lo = degrees_q32(lo_e, lon_ref);
                        if (la != 0 || lo != 0) geo = 1'b1;
                        else begin
                            la = 0;
                            lo = 0;
                        end
                    end
                end
            end
        end
        r = '{kind: KIND_STATUS, text: 64'd0, count: 4'd0, ok: ok, geo: geo,
              lat: geo ? la : 64'd0, lon: geo ? lo : 64'd0, last: 1'b1};
        pending_records.push_back(r);
    endfunction

    function automatic void take_file_word(input logic [7:0] b, input logic eof);
        walk_byte(b);
        if (eof) begin
            walk_directories();
            clear_parser();
        end
    endfunction

    // Results are checked before the word taken at the same edge is predicted; values
    // read here are those from before the edge, so no race with the block's updates.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_records.size() == 0) begin
                report_mismatch("record with none expected", {62'd0, o_record_kind}, 64'd0);
            end else begin
                got_rec = pending_records.pop_front();
                if (o_record_kind !== got_rec.kind)
                    report_mismatch("record_kind", {62'd0, o_record_kind}, {62'd0, got_rec.kind});
                if (o_chunk_bytes !== got_rec.text)
                    report_mismatch("chunk_bytes", o_chunk_bytes, got_rec.text);
                if (o_chunk_count !== got_rec.count)
                    report_mismatch("chunk_count", {60'd0, o_chunk_count}, {60'd0, got_rec.count});
                if (o_parse_ok !== got_rec.ok)
                    report_mismatch("parse_ok", {63'd0, o_parse_ok}, {63'd0, got_rec.ok});
                if (o_has_geo !== got_rec.geo)
                    report_mismatch("has_geo", {63'd0, o_has_geo}, {63'd0, got_rec.geo});
                if (o_latitude !== got_rec.lat)
                    report_mismatch("latitude", o_latitude, got_rec.lat);
                if (o_longitude !== got_rec.lon)
                    report_mismatch("longitude", o_longitude, got_rec.lon);
                if (o_last_of_run !== got_rec.last)
                    report_mismatch("last_of_run", {63'd0, o_last_of_run}, {63'd0, got_rec.last});
            end
            records_seen++;
        end
        if (i_rst_n && start && !busy) take_file_word(i_data_byte, i_end_of_file);
    end

    // Watchdog: a long stretch with neither a word taken nor a record shown ends the run.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_jpeg_exif_gps_extractor: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sending. start stays high across words; it drops only for an idle burst or a drain.
    // ------------------------------------------------------------------
    task automatic send_word(input logic [7:0] b, input logic eof);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_data_byte <= b;
        i_end_of_file <= eof;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < jpeg_img.size(); i++)
            send_word(jpeg_img[i], i == jpeg_img.size() - 1);
    endtask

    // Stop sending and wait until every expected record has been seen.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_records.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // File construction.
    // ------------------------------------------------------------------
    function automatic void put16(input logic [15:0] v);
        if (img_intel) begin
            tiff_img.push_back(v[7:0]);
            tiff_img.push_back(v[15:8]);
        end else begin
            tiff_img.push_back(v[15:8]);
            tiff_img.push_back(v[7:0]);
        end
    endfunction

    function automatic void put32(input logic [31:0] v);
        if (img_intel) begin
            put16(v[15:0]);
            put16(v[31:16]);
        end else begin
            put16(v[31:16]);
            put16(v[15:0]);
        end
    endfunction

    function automatic void patch32(input int pos, input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            tiff_img[pos + i] = img_intel ? v[8*i +: 8] : v[8*(3-i) +: 8];
    endfunction

    function automatic int add_entry(input logic [15:0] tag, input logic [15:0] kind,
                                     input logic [31:0] cnt);
        int pos;
        pos = tiff_img.size();
        put16(tag);
        put16(kind);
        put32(cnt);
        put32(32'd0);
        return pos;
    endfunction

    function automatic logic [7:0] text_char();
        return ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
    endfunction

    // ASCII text of len characters for the entry at pos; short counts sit inline.
    function automatic void put_text(input int pos, input int len);
        logic [31:0] cnt;
        cnt = len + 1;
        patch32(pos + 4, cnt);
        if (cnt <= 4) begin
            for (int i = 0; i < len; i++) tiff_img[pos + 8 + i] = text_char();
            tiff_img[pos + 8 + len] = 8'h00;
        end else begin
            patch32(pos + 8, tiff_img.size());
            for (int i = 0; i < len; i++) tiff_img.push_back(text_char());
            tiff_img.push_back(8'h00);
        end
    endfunction

    // Three rationals for one coordinate; mode picks plain, zero, saturating or broken.
    function automatic void put_angle(input int pos, input int mode);
        patch32(pos + 8, (mode == 5) ? 32'hFFFF_FFF0 : 32'(tiff_img.size()));
        for (int t = 0; t < 3; t++) begin
            case (mode)
                3: begin
                    put32(32'd0);
                    put32(32'($urandom_range(0, 9)));
                end
                4: begin
                    put32(32'hFFFF_FFFF);
                    put32(32'd1);
                end
                default: begin
                    put32($urandom());
                    put32(($urandom_range(0, 9) == 0) ? 32'd0 :
                          ($urandom_range(0, 1) ? 32'd1 : $urandom_range(1, 100000)));
                end
            endcase
        end
    endfunction

    // TIFF block: header, IFD0 with the text tags present (length -1 leaves a tag out)
    // and, for gps_mode above zero, a GPS directory.
    function automatic void build_tiff(input bit intel, input int mk, input int md,
                                       input int dt, input int gps_mode);
        int pos_mk, pos_md, pos_dt, pos_gps, pos_la, pos_lo, pos_ref;
        int n;
        img_intel = intel;
        tiff_img.delete();
        tiff_img.push_back(intel ? 8'h49 : 8'h4D);
        tiff_img.push_back(intel ? 8'h49 : 8'h4D);
        put16(16'd42);
        put32(32'd8);
        n = (mk >= 0) + (md >= 0) + (dt >= 0) + (gps_mode > 0);
        put16(16'(n));
        if (mk >= 0) pos_mk = add_entry(TAG_MAKE, 16'd2, 32'd0);
        if (md >= 0) pos_md = add_entry(TAG_MODEL, 16'd2, 32'd0);
        if (dt >= 0) pos_dt = add_entry(TAG_DATETIME, 16'd2, 32'd0);
        if (gps_mode > 0) pos_gps = add_entry(TAG_GPS_IFD, 16'd4, 32'd1);
        put32(32'd0);
        if (mk >= 0) put_text(pos_mk, mk);
        if (md >= 0) put_text(pos_md, md);
        if (dt >= 0) put_text(pos_dt, dt);
        if (gps_mode > 0) begin
            patch32(pos_gps + 8, tiff_img.size());
            put16(16'd4);
            pos_ref = add_entry(TAG_LAT_REF, 16'd2, (gps_mode == 2) ? 32'd8 : 32'd2);
            if (gps_mode == 2) patch32(pos_ref + 8, 32'hFFFF_0000);
            else tiff_img[pos_ref + 8] = $urandom_range(0, 1) ? ASCII_N : ASCII_S;
            pos_la = add_entry(TAG_LAT, 16'd5, 32'd3);
            pos_ref = add_entry(TAG_LON_REF, 16'd2, 32'd2);
            tiff_img[pos_ref + 8] = $urandom_range(0, 1) ? ASCII_E : ASCII_W;
            pos_lo = add_entry(TAG_LON, 16'd5, 32'd3);
            put32(32'd0);
            put_angle(pos_la, gps_mode);
            put_angle(pos_lo, gps_mode);
        end
    endfunction

    function automatic void push_segment_head(input logic [7:0] id, input int seg_len);
        jpeg_img.push_back(MARK_FF);
        jpeg_img.push_back(id);
        jpeg_img.push_back(8'(seg_len >> 8));
        jpeg_img.push_back(8'(seg_len));
    endfunction

    // Exif APP1 around the current TIFF block; seg_len below zero means the true length.
    function automatic void push_app1(input int seg_len);
        push_segment_head(MARK_APP1, (seg_len < 0) ? tiff_img.size() + 8 : seg_len);
        foreach (SIG_BYTES[i]) jpeg_img.push_back(SIG_BYTES[i]);
        foreach (tiff_img[i]) jpeg_img.push_back(tiff_img[i]);
    endfunction

    function automatic void wrap_jpeg(input int app1_len, input bit app0, input bit sos);
        int k;
        jpeg_img = '{MARK_FF, MARK_SOI};
        if (app0) begin
            k = $urandom_range(0, 6);
            push_segment_head(8'hE0, k + 2);
            repeat (k) jpeg_img.push_back(8'($urandom()));
        end
        push_app1(app1_len);
        if (sos) begin
            push_segment_head(MARK_SOS, 2);
            repeat ($urandom_range(1, 4)) jpeg_img.push_back(8'($urandom()));
        end
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Broken headers: lone byte, wrong start mark, scan before Exif, length below two, a short
    // APP1 whose length ends inside the signature, and a signature mismatch in a long APP1.
    task automatic test_marker_walk();
        jpeg_img = '{8'h00};
        send_file();
        jpeg_img = '{8'hFF};
        send_file();
        build_tiff(1'b1, 3, 5, -1, 0);
        wrap_jpeg(-1, 1'b0, 1'b0);
        jpeg_img[1] = 8'hD9;
        send_file();
        jpeg_img = '{MARK_FF, MARK_SOI};
        push_segment_head(MARK_SOS, 2);
        push_app1(-1);
        send_file();
        jpeg_img = '{MARK_FF, MARK_SOI};
        push_segment_head(8'hE0, 1);
        push_app1(-1);
        send_file();
        // Signature cut short, next byte is a marker start: walk resumes.
        jpeg_img = '{MARK_FF, MARK_SOI, MARK_FF, MARK_APP1, 8'h00, 8'h04, 8'h45, 8'h78, MARK_FF};
        jpeg_img.push_back(MARK_APP1);
        jpeg_img.push_back(8'((tiff_img.size() + 8) >> 8));
        jpeg_img.push_back(8'(tiff_img.size() + 8));
        foreach (SIG_BYTES[i]) jpeg_img.push_back(SIG_BYTES[i]);
        foreach (tiff_img[i]) jpeg_img.push_back(tiff_img[i]);
        send_file();
        // Same but the byte at the segment end is not a marker: the rest is ignored.
        jpeg_img = '{MARK_FF, MARK_SOI, MARK_FF, MARK_APP1, 8'h00, 8'h04, 8'h45, 8'h78, 8'h12};
        push_app1(-1);
        send_file();
        // A mismatch well inside a long APP1 skips it; a later Exif APP1 is captured.
        jpeg_img = '{MARK_FF, MARK_SOI, MARK_FF, MARK_APP1, 8'h00, 8'h0A, 8'h45, 8'h00};
        repeat (6) jpeg_img.push_back(8'($urandom()));
        push_app1(-1);
        send_file();
    endtask

    // Text tags in both byte orders, including strings long enough to hit the caps.
    task automatic test_text_tags();
        build_tiff(1'b1, 0, 3, 19, 0);
        wrap_jpeg(-1, 1'b1, 1'b1);
        send_file();
        build_tiff(1'b0, 8, 1, 4, 0);
        wrap_jpeg(-1, 1'b0, 1'b1);
        send_file();
        build_tiff(1'b1, 140, 135, 70, 4);
        wrap_jpeg(-1, 1'b0, 1'b0);
        send_file();
        // Entry count raised to two and a byte inserted ahead of the make entry: no known tag is left.
        build_tiff(1'b0, 9, -1, -1, 0);
        tiff_img[8] = 8'h00;
        tiff_img[9] = 8'h02;
        tiff_img.insert(10, 8'h00);
        wrap_jpeg(-1, 1'b0, 1'b0);
        send_file();
    endtask

    // GPS: plain, reference out of range, zero coordinates, saturation, bad offsets.
    task automatic test_gps_directory();
        for (int m = 1; m <= 5; m++) begin
            build_tiff(m[0], 4, -1, 10, m);
            wrap_jpeg(-1, m > 3, 1'b1);
            send_file();
            if (m == 3) drain();
        end
    endtask

    // Short APP1 length captures to end of file, clamped to store size; a truncated file.
    task automatic test_capture_limits();
        build_tiff(1'b1, 12, 12, 12, 1);
        wrap_jpeg(4, 1'b0, 1'b0);
        send_file();
        build_tiff(1'b0, 6, -1, -1, 1);
        wrap_jpeg(-1, 1'b0, 1'b0);
        jpeg_img = jpeg_img[0:jpeg_img.size() - 20];
        send_file();
        build_tiff(1'b1, 20, 7, 19, 1);
        while (tiff_img.size() < STORE_BYTES + 64) tiff_img.push_back(8'($urandom()));
        jpeg_img = '{MARK_FF, MARK_SOI};
        push_app1(7);
        send_file();
        drain();
    endtask

    function automatic int text_len();
        case ($urandom_range(0, 9))
            0: return -1;
            1: return $urandom_range(100, 140);
            default: return $urandom_range(0, 24);
        endcase
    endfunction

    // Mostly well-formed files with random content; the rest noise or damaged files.
    task automatic test_random_files();
        int kind, n;
        while (words_sent < 420 || records_seen < 60) begin
            if (words_sent > 330) gaps_on = 1'b0;
            kind = $urandom_range(0, 19);
            build_tiff($urandom_range(0, 1), text_len(), text_len(), text_len(),
                       $urandom_range(0, 3) ? 1 : $urandom_range(0, 5));
            wrap_jpeg((kind == 3) ? $urandom_range(0, 20) : -1, $urandom_range(0, 1),
                      $urandom_range(0, 1));
            if (kind == 0) begin
                jpeg_img.delete();
                repeat ($urandom_range(1, 40)) jpeg_img.push_back(8'($urandom()));
            end else if (kind == 1) begin
                repeat (3) jpeg_img[$urandom_range(0, jpeg_img.size() - 1)] = 8'($urandom());
            end else if (kind == 2) begin
                n = $urandom_range(1, jpeg_img.size());
                jpeg_img = jpeg_img[0:n - 1];
            end
            send_file();
        end
    endtask

    initial begin
        clear_parser();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_marker_walk();
        test_text_tags();
        test_gps_directory();
        test_capture_limits();
        test_random_files();
        drain();
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_jpeg_exif_gps_extractor: clean");
        end else begin
            $display("tb_jpeg_exif_gps_extractor: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/jegx_pkg.sv
rtl/core/jegx_div.sv
rtl/core/jpeg_exif_gps_extractor.sv
test/tb_jpeg_exif_gps_extractor.sv
